/* hdl/sna_pkg.sv */
// Shared types and fixed-point constants of the Snake activation unit.
package sna_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int CHANNEL_W  = 9;
    localparam int ANGLE_W    = 48;
    localparam int MAG_W      = 47;
    localparam int Z_W        = 34;
    localparam int XY_W       = 35;
    localparam int RED_STAGES = 14;
    localparam int ATAN_ENTRIES = 24;

    localparam logic [33:0] TWO_PI_Q30   = 34'd6746518852;
    localparam logic [33:0] PI_Q30       = 34'd3373259426;
    localparam logic [33:0] HALF_PI_Q30  = 34'd1686629713;
    localparam logic [33:0] PI_1P5_Q30   = 34'd5059889139;
    localparam logic [34:0] GAIN_Q30     = 35'd652032874;

    localparam logic [33:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        34'd843314857, 34'd497837829, 34'd263043837, 34'd133525159,
        34'd67021687,  34'd33543516,  34'd16775851,  34'd8388437,
        34'd4194283,   34'd2097149,   34'd1048576,   34'd524288,
        34'd262144,    34'd131072,    34'd65536,     34'd32768,
        34'd16384,     34'd8192,      34'd4096,      34'd2048,
        34'd1024,      34'd512,       34'd256,       34'd128
    };

    typedef enum logic [1:0] {
        CFG_ALPHA_SHARED   = 2'd0,
        CFG_INVERSE_SHARED = 2'd1
    } cfg_index_t;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] inv;
    } side_t;

endpackage

/* hdl/snake_activation_unit.sv */
// Top level of the Snake activation unit: tables, range reduction and output math.
//
// Input items arrive on the s_ channel. tuser carries the mode: a load item
// writes the alpha and inverse of one channel into two on-chip tables and
// gives no result; a sample item reads its channel's parameters and gives
// one result item on the m_ channel, y = x + inverse * sin(alpha * x)^2.
// The cfg_ channel sets the two shared-parameter flags and is always ready;
// write it only while no item is in flight.
// The pipeline takes one item per cycle while the output is not held. Its
// depth is set by the fourteen range-reduction stages and one stage per
// CORDIC step.
// Results leave through an output register. When the receiver holds
// m_tready low with a result waiting, the whole pipeline holds and s_tready
// drops; otherwise a new item is taken every cycle.
// Reset clears the pipeline valid bits and both flags; the tables keep
// their contents and must be loaded before a channel is sampled. A load
// followed at once by a sample of the same channel sees the new values.
module snake_activation_unit #(
    parameter int CHANNELS     = 512,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // channel, sample, alpha_value, inverse_value, zero pad
    input  logic [0:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // result
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [0:0]  cfg_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RECIP_SHIFT = 22;
    localparam logic [22:0] RECIP = 23'((2 ** RECIP_SHIFT + CHANNELS - 1) / CHANNELS);

    logic en;
    logic alpha_shared_reg;
    logic inverse_shared_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_shared_reg   <= 1'b0;
            inverse_shared_reg <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == sna_pkg::CFG_ALPHA_SHARED) begin
                alpha_shared_reg <= cfg_data[0];
            end
            if (cfg_index == sna_pkg::CFG_INVERSE_SHARED) begin
                inverse_shared_reg <= cfg_data[0];
            end
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Input stage: the channel quotient is found by a reciprocal multiply.
    logic        s0_v_reg;
    logic        s0_mode_reg;
    logic [8:0]  s0_ch_reg;
    logic [8:0]  s0_q_reg;
    logic signed [23:0] s0_x_reg;
    logic signed [23:0] s0_alpha_reg;
    logic signed [23:0] s0_inv_reg;
    logic [31:0] q_prod;

    assign q_prod = 32'(s_tdata[8:0]) * 32'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_v_reg <= 1'b0;
        end else if (en) begin
            s0_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_mode_reg  <= s_tuser[0];
            s0_ch_reg    <= s_tdata[8:0];
            s0_q_reg     <= q_prod[RECIP_SHIFT+8:RECIP_SHIFT];
            s0_x_reg     <= $signed(s_tdata[32:9]);
            s0_alpha_reg <= $signed(s_tdata[56:33]);
            s0_inv_reg   <= $signed(s_tdata[80:57]);
        end
    end

    // Table stage: loads write, samples read.
    logic [23:0] alpha_mem   [CHANNELS];
    logic [23:0] inverse_mem [CHANNELS];
    logic [21:0] ch_mod_full;
    logic [AW-1:0] ch_mod;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] alpha_raddr;
    logic [AW-1:0] inverse_raddr;
    logic          wr_en;

    assign ch_mod_full   = 22'(s0_ch_reg) - 22'(s0_q_reg) * 22'(CHANNELS);
    assign ch_mod        = AW'(ch_mod_full);
    assign wr_addr       = AW'(s0_ch_reg);
    assign wr_en         = en && s0_v_reg && (s0_mode_reg == sna_pkg::MODE_LOAD)
                           && (32'(s0_ch_reg) < 32'(CHANNELS));
    assign alpha_raddr   = alpha_shared_reg   ? '0 : ch_mod;
    assign inverse_raddr = inverse_shared_reg ? '0 : ch_mod;

    logic        s1_v_reg;
    logic signed [23:0] s1_x_reg;
    logic [23:0] s1_alpha_reg;
    logic [23:0] s1_inv_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (wr_en) begin
                alpha_mem[wr_addr]   <= s0_alpha_reg;
                inverse_mem[wr_addr] <= s0_inv_reg;
            end
            s1_alpha_reg <= alpha_mem[alpha_raddr];
            s1_inv_reg   <= inverse_mem[inverse_raddr];
            s1_x_reg     <= s0_x_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg <= s0_v_reg && (s0_mode_reg == sna_pkg::MODE_SAMPLE);
        end
    end

    // Angle product alpha * x in Q.30.
    logic        s2_v_reg;
    logic signed [sna_pkg::ANGLE_W-1:0] s2_ang_reg;
    sna_pkg::side_t s2_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_v_reg <= 1'b0;
        end else if (en) begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_ang_reg      <= $signed(s1_alpha_reg) * s1_x_reg;
            s2_side_reg.x   <= s1_x_reg;
            s2_side_reg.inv <= $signed(s1_inv_reg);
        end
    end

    // Range reduction: magnitude, then one conditional subtract of 2*pi*2^j per stage, j from 13 down to 0.
    logic                         red_v_reg    [sna_pkg::RED_STAGES+1];
    logic [sna_pkg::MAG_W-1:0]    red_m_reg    [sna_pkg::RED_STAGES+1];
    logic                         red_n_reg    [sna_pkg::RED_STAGES+1];
    sna_pkg::side_t               red_side_reg [sna_pkg::RED_STAGES+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_v_reg[0] <= 1'b0;
        end else if (en) begin
            red_v_reg[0] <= s2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            red_n_reg[0]    <= s2_ang_reg[sna_pkg::ANGLE_W-1];
            red_m_reg[0]    <= s2_ang_reg[sna_pkg::ANGLE_W-1]
                               ? sna_pkg::MAG_W'(-s2_ang_reg)
                               : sna_pkg::MAG_W'(s2_ang_reg);
            red_side_reg[0] <= s2_side_reg;
        end
    end

    for (genvar k = 1; k <= sna_pkg::RED_STAGES; k++) begin : g_red
        localparam logic [sna_pkg::MAG_W-1:0] SUB =
            sna_pkg::MAG_W'(sna_pkg::TWO_PI_Q30) << (sna_pkg::RED_STAGES - k);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                red_v_reg[k] <= 1'b0;
            end else if (en) begin
                red_v_reg[k] <= red_v_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                red_n_reg[k]    <= red_n_reg[k-1];
                red_side_reg[k] <= red_side_reg[k-1];
                red_m_reg[k]    <= (red_m_reg[k-1] >= SUB) ? red_m_reg[k-1] - SUB
                                                           : red_m_reg[k-1];
            end
        end
    end

    // Floor modulo for negative angles, then fold into [-pi/2, pi/2].
    logic        f1_v_reg;
    logic [33:0] f1_r_reg;
    sna_pkg::side_t f1_side_reg;
    logic [33:0] rem;

    assign rem = red_m_reg[sna_pkg::RED_STAGES][33:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_v_reg <= 1'b0;
        end else if (en) begin
            f1_v_reg <= red_v_reg[sna_pkg::RED_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_side_reg <= red_side_reg[sna_pkg::RED_STAGES];
            f1_r_reg    <= (red_n_reg[sna_pkg::RED_STAGES] && (rem != '0))
                           ? sna_pkg::TWO_PI_Q30 - rem : rem;
        end
    end

    logic        f2_v_reg;
    logic signed [sna_pkg::Z_W-1:0] f2_z_reg;
    sna_pkg::side_t f2_side_reg;
    logic signed [34:0] r0s;
    logic signed [34:0] z_next;

    assign r0s = $signed({1'b0, f1_r_reg});

    always_comb begin
        if ((f1_r_reg > sna_pkg::HALF_PI_Q30) && (f1_r_reg < sna_pkg::PI_1P5_Q30)) begin
            z_next = $signed({1'b0, sna_pkg::PI_Q30}) - r0s;
        end else if (f1_r_reg >= sna_pkg::PI_Q30) begin
            z_next = r0s - $signed({1'b0, sna_pkg::TWO_PI_Q30});
        end else begin
            z_next = r0s;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f2_v_reg <= 1'b0;
        end else if (en) begin
            f2_v_reg <= f1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f2_z_reg    <= sna_pkg::Z_W'(z_next);
            f2_side_reg <= f1_side_reg;
        end
    end

    logic cord_v;
    logic signed [sna_pkg::XY_W-1:0] cord_s;
    sna_pkg::side_t cord_side;

    sna_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (f2_v_reg),
        .in_z     (f2_z_reg),
        .in_side  (f2_side_reg),
        .out_valid(cord_v),
        .out_sin  (cord_s),
        .out_side (cord_side)
    );

    // Square of the sine, rounded to Q.30.
    logic        sq_v_reg;
    logic [33:0] sq_reg;
    sna_pkg::side_t sq_side_reg;
    logic [31:0] sin_mag;
    logic [63:0] sq_prod;

    assign sin_mag = (cord_s < 0) ? 32'(-cord_s) : 32'(cord_s);
    assign sq_prod = 64'(sin_mag) * 64'(sin_mag);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg <= 1'b0;
        end else if (en) begin
            sq_v_reg <= cord_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg      <= 34'((sq_prod + (64'd1 << 29)) >> 30);
            sq_side_reg <= cord_side;
        end
    end

    // Scale by the inverse.
    logic        pr_v_reg;
    logic signed [58:0] pr_reg;
    logic signed [23:0] pr_x_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pr_v_reg <= 1'b0;
        end else if (en) begin
            pr_v_reg <= sq_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pr_reg   <= sq_side_reg.inv * $signed({1'b0, sq_reg});
            pr_x_reg <= sq_side_reg.x;
        end
    end

    // Round, add x and saturate into the output register.
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic signed [58:0] pr_round;
    logic signed [28:0] term;
    logic signed [29:0] y_sum;
    logic [23:0] y_next;

    assign pr_round = pr_reg + (59'sd1 <<< 29);
    assign term     = pr_round[58:30];
    assign y_sum    = 30'(pr_x_reg) + 30'(term);

    always_comb begin
        if (y_sum > 30'sd8388607) begin
            y_next = 24'h7FFFFF;
        end else if (y_sum < -30'sd8388608) begin
            y_next = 24'h800000;
        end else begin
            y_next = y_sum[23:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= pr_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= y_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* hdl/sna_cordic.sv */
// Pipelined CORDIC rotation, one step per stage, returning the sine of the angle.
module sna_cordic #(
    parameter int STEPS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [sna_pkg::Z_W-1:0]    in_z,
    input  sna_pkg::side_t                    in_side,
    output logic                              out_valid,
    output logic signed [sna_pkg::XY_W-1:0]   out_sin,
    output sna_pkg::side_t                    out_side
);

    logic                            v_reg    [STEPS];
    logic signed [sna_pkg::XY_W-1:0] x_reg    [STEPS];
    logic signed [sna_pkg::XY_W-1:0] y_reg    [STEPS];
    logic signed [sna_pkg::Z_W-1:0]  z_reg    [STEPS];
    sna_pkg::side_t                  side_reg [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic                            cv;
        logic signed [sna_pkg::XY_W-1:0] cx;
        logic signed [sna_pkg::XY_W-1:0] cy;
        logic signed [sna_pkg::Z_W-1:0]  cz;
        sna_pkg::side_t                  cs;

        if (i == 0) begin : g_first
            assign cv = in_valid;
            assign cx = $signed(sna_pkg::GAIN_Q30);
            assign cy = '0;
            assign cz = in_z;
            assign cs = in_side;
        end else begin : g_later
            assign cv = v_reg[i-1];
            assign cx = x_reg[i-1];
            assign cy = y_reg[i-1];
            assign cz = z_reg[i-1];
            assign cs = side_reg[i-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= cv;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[i] <= cs;
                if (cz >= 0) begin
                    x_reg[i] <= cx - (cy >>> i);
                    y_reg[i] <= cy + (cx >>> i);
                    z_reg[i] <= cz - $signed(sna_pkg::ATAN_Q30[i]);
                end else begin
                    x_reg[i] <= cx + (cy >>> i);
                    y_reg[i] <= cy - (cx >>> i);
                    z_reg[i] <= cz + $signed(sna_pkg::ATAN_Q30[i]);
                end
            end
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign out_sin   = y_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule
